>>> hdl/hrlp_pkg.sv
package hrlp_pkg;

  // Width of the version number ports.
  localparam int unsigned NumberWidth = 16;

  // Parse phases of the request line.
  typedef enum logic [3:0] {
    PH_CMD0  = 4'd0,
    PH_CMD   = 4'd1,
    PH_URL0  = 4'd2,
    PH_URL   = 4'd3,
    PH_QUERY = 4'd4,
    PH_PROTO = 4'd5,
    PH_MAJOR = 4'd6,
    PH_MINOR = 4'd7,
    PH_END0  = 4'd8
  } phase_t;

  // Byte classification codes.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_METHOD = 2'd1,
    KIND_PATH   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  // Characters the parser looks for.
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChSlash    = 8'h2F;
  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;

endpackage

>>> hdl/http_request_line_parser.sv
// HTTP request line parser.
//
// The input channel (in_valid, in_ready, data_byte, end_of_input) takes one
// raw byte of the request stream per transfer. The output channel
// (out_valid, out_ready, echo_byte, byte_kind, major_number, minor_number,
// line_done, line_error) returns exactly one result per input byte, in order.
// Each byte is classified as method, path or query text or as none, and the version
// numbers after the protocol slash are accumulated with saturation at
// 2^VERSION_WIDTH - 1; the ports carry their low 16 bits.
// The result of a byte is registered: it is in the output register the
// cycle after its transfer. The parser takes one byte per cycle unless the
// receiver stalls; the phase update for a byte feeds the next byte.
// When the receiver stalls, the result holds in the output register and a new
// byte is taken only in a cycle in which that result is being taken.
// A synchronous reset returns the parser to waiting for a method and empties
// the output register. After a completed line, or a byte marked as the last
// of the stream, the parser returns to the same reset state.
module http_request_line_parser #(
  parameter int unsigned VERSION_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  input  logic                                 end_of_input,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           echo_byte,
  output logic [1:0]                           byte_kind,
  output logic [hrlp_pkg::NumberWidth-1:0]     major_number,
  output logic [hrlp_pkg::NumberWidth-1:0]     minor_number,
  output logic                                 line_done,
  output logic                                 line_error
);

  localparam int unsigned ProdWidth = VERSION_WIDTH + 4;
  localparam int unsigned WideWidth =
    (VERSION_WIDTH > hrlp_pkg::NumberWidth) ? VERSION_WIDTH : hrlp_pkg::NumberWidth;
  localparam logic [ProdWidth-1:0] VersionMax = {4'b0, {VERSION_WIDTH{1'b1}}};

  hrlp_pkg::phase_t           phase, phase_next;
  logic [VERSION_WIDTH-1:0]   major_acc, major_acc_next;
  logic [VERSION_WIDTH-1:0]   minor_acc, minor_acc_next;
  logic                       error_flag, error_flag_next;
  hrlp_pkg::kind_t            kind_next;
  logic                       done_next;
  logic                       is_ws, is_digit;
  logic                       in_fire;
  logic [ProdWidth-1:0]       digit_value;
  logic [ProdWidth-1:0]       major_prod, minor_prod;
  logic [VERSION_WIDTH-1:0]   major_sat, minor_sat;
  logic [WideWidth-1:0]       major_wide, minor_wide;
  logic [VERSION_WIDTH-1:0]   major_res, minor_res;

  // A new byte is taken whenever the output register is empty or draining.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Character classes.
  assign is_ws    = (data_byte == hrlp_pkg::ChSpace) ||
                    ((data_byte >= hrlp_pkg::ChTab) && (data_byte <= hrlp_pkg::ChCr));
  assign is_digit = (data_byte >= hrlp_pkg::ChZero) && (data_byte <= hrlp_pkg::ChNine);

  // Decimal accumulate: acc * 10 + digit as two shifts and two adds, saturated.
  assign digit_value = ProdWidth'(data_byte - hrlp_pkg::ChZero);
  assign major_prod  = (ProdWidth'(major_acc) << 3) + (ProdWidth'(major_acc) << 1)
                       + digit_value;
  assign minor_prod  = (ProdWidth'(minor_acc) << 3) + (ProdWidth'(minor_acc) << 1)
                       + digit_value;
  assign major_sat   = (major_prod > VersionMax) ? VERSION_WIDTH'(VersionMax)
                                                 : VERSION_WIDTH'(major_prod);
  assign minor_sat   = (minor_prod > VersionMax) ? VERSION_WIDTH'(VersionMax)
                                                 : VERSION_WIDTH'(minor_prod);

  // Phase decode for the current byte.
  always_comb begin
    phase_next      = phase;
    major_acc_next  = major_acc;
    minor_acc_next  = minor_acc;
    error_flag_next = error_flag;
    kind_next       = hrlp_pkg::KIND_NONE;
    done_next       = 1'b0;
    unique case (phase)
      hrlp_pkg::PH_CMD: begin
        if (is_ws) phase_next = hrlp_pkg::PH_URL0;
        else kind_next = hrlp_pkg::KIND_METHOD;
      end
      hrlp_pkg::PH_URL0: begin
        if (!is_ws) begin
          kind_next  = hrlp_pkg::KIND_PATH;
          phase_next = hrlp_pkg::PH_URL;
        end
      end
      hrlp_pkg::PH_URL: begin
        priority if (data_byte == hrlp_pkg::ChQuestion) phase_next = hrlp_pkg::PH_QUERY;
        else if (is_ws) phase_next = hrlp_pkg::PH_PROTO;
        else kind_next = hrlp_pkg::KIND_PATH;
      end
      hrlp_pkg::PH_QUERY: begin
        if (is_ws) phase_next = hrlp_pkg::PH_PROTO;
        else kind_next = hrlp_pkg::KIND_QUERY;
      end
      hrlp_pkg::PH_PROTO: begin
        if (data_byte == hrlp_pkg::ChSlash) phase_next = hrlp_pkg::PH_MAJOR;
        else if (data_byte == hrlp_pkg::ChCr) error_flag_next = 1'b1;
      end
      hrlp_pkg::PH_MAJOR: begin
        priority if (data_byte == hrlp_pkg::ChDot) phase_next = hrlp_pkg::PH_MINOR;
        else if (is_digit) major_acc_next = major_sat;
        else error_flag_next = 1'b1;
      end
      hrlp_pkg::PH_MINOR: begin
        priority if (is_ws) phase_next = hrlp_pkg::PH_END0;
        else if (is_digit) minor_acc_next = minor_sat;
        else error_flag_next = 1'b1;
      end
      hrlp_pkg::PH_END0: begin
        if (data_byte == hrlp_pkg::ChLf) done_next = 1'b1;
      end
      default: begin
        // Waiting for the first method byte; unused codes behave the same.
        if (!is_ws) begin
          kind_next  = hrlp_pkg::KIND_METHOD;
          phase_next = hrlp_pkg::PH_CMD;
        end
      end
    endcase
    // A stream that ends before the line completes is an error.
    if (end_of_input && !done_next) error_flag_next = 1'b1;
  end

  // Parser state advances on each input transfer and restarts after a line.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hrlp_pkg::PH_CMD0;
      major_acc  <= '0;
      minor_acc  <= '0;
      error_flag <= 1'b0;
    end else if (in_fire) begin
      if (done_next || end_of_input) begin
        phase      <= hrlp_pkg::PH_CMD0;
        major_acc  <= '0;
        minor_acc  <= '0;
        error_flag <= 1'b0;
      end else begin
        phase      <= phase_next;
        major_acc  <= major_acc_next;
        minor_acc  <= minor_acc_next;
        error_flag <= error_flag_next;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Output register payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      echo_byte  <= data_byte;
      byte_kind  <= kind_next;
      major_res  <= major_acc_next;
      minor_res  <= minor_acc_next;
      line_done  <= done_next;
      line_error <= error_flag_next;
    end
  end

  // Version ports carry the low bits of the accumulators.
  assign major_wide   = WideWidth'(major_res);
  assign minor_wide   = WideWidth'(minor_res);
  assign major_number = major_wide[hrlp_pkg::NumberWidth-1:0];
  assign minor_number = minor_wide[hrlp_pkg::NumberWidth-1:0];

`ifndef SYNTHESIS
  // A completed line is always reported on its newline byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> echo_byte == hrlp_pkg::ChLf)
    else $error("line_done on a byte that is not a newline");

  // A classified text byte never completes a line.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind != hrlp_pkg::KIND_NONE |-> !line_done)
    else $error("text byte reported as line completion");

  // The parser restarts after a finished line or the end of the stream.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && (done_next || end_of_input) |=>
      phase == hrlp_pkg::PH_CMD0 && major_acc == '0 && minor_acc == '0 && !error_flag)
    else $error("parser state not cleared after end of line");

  // The error flag stays set for the rest of the line.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && error_flag && !done_next && !end_of_input |=> error_flag)
    else $error("error flag dropped within a line");
`endif

endmodule
